FILE: hdl/adb_pkg.sv
`default_nettype none

package adb_pkg;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned TIMER_W = 32;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [TIMER_W-1:0] timer_t;

	localparam action_t ACT_SAMPLE = 2'd0;
	localparam action_t ACT_RESTART = 2'd1;
	localparam action_t ACT_ENABLE = 2'd2;
	localparam action_t ACT_DISABLE = 2'd3;

	localparam cfg_idx_t REG_TICK_PERIOD = 2'd0;
	localparam cfg_idx_t REG_RISE_DELAY = 2'd1;
	localparam cfg_idx_t REG_FALL_DELAY = 2'd2;

	localparam timer_t TICK_PERIOD_RESET = 32'd1;

	// filter state carried from one transaction to the next
	typedef struct packed {
		logic   enabled;
		logic   startup_pending;
		logic   restart_pending;
		logic   last_raw;
		logic   out_level;
		logic   last_out;
		timer_t hold_timer;
	} filt_state_t;

	localparam filt_state_t FILT_STATE_RESET = '{
		enabled:         1'b0,
		startup_pending: 1'b1,
		restart_pending: 1'b0,
		last_raw:        1'b0,
		out_level:       1'b0,
		last_out:        1'b0,
		hold_timer:      '0
	};

endpackage

`default_nettype wire

FILE: hdl/asymmetric_delay_debouncer.sv
// channel | handshake            | payload
// in      | in_valid / in_ready   | action[1:0], sample_level
// out     | out_valid / out_ready | filtered_level, raw_level, rise_event, fall_event, is_enabled
// cfg     | cfg_we (no wait)      | cfg_index[1:0], cfg_data[31:0]
//
// one transaction per cycle sustained while out_ready stays high; out_valid rises once an accepted
// transaction passes the input register, then timer compare/subtract/reload into the result register
// arst_n resets the filter state (disabled, startup pending), tick_period to 1 and both delays to 0
// a stalled result holds the input register; in_ready stays high while the result moves on
`default_nettype none

module asymmetric_delay_debouncer (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  adb_pkg::action_t action,
	input  wire                    sample_level,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic                   filtered_level,
	output logic                   raw_level,
	output logic                   rise_event,
	output logic                   fall_event,
	output logic                   is_enabled,
	input  wire                    cfg_we,
	input  wire  adb_pkg::cfg_idx_t  cfg_index,
	input  wire  adb_pkg::cfg_data_t cfg_data
);
	import adb_pkg::*;

	timer_t tick_period_q;
	timer_t rise_delay_q;
	timer_t fall_delay_q;

	logic        valid_s1;
	action_t     action_s1;
	logic        level_s1;

	filt_state_t st_q;
	filt_state_t st_nxt;
	logic        rise_nxt;
	logic        fall_nxt;

	logic        out_valid_q;
	logic        advance;

	timer_t      timer_in;
	timer_t      timer_dec;
	logic        samp_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= TICK_PERIOD_RESET;
			rise_delay_q  <= '0;
			fall_delay_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_PERIOD: tick_period_q <= cfg_data;
				REG_RISE_DELAY:  rise_delay_q  <= cfg_data;
				REG_FALL_DELAY:  fall_delay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			level_s1  <= sample_level;
		end
	end

	// sample datapath: pending restart zeroes the timer first
	assign timer_in  = st_q.restart_pending ? '0 : st_q.hold_timer;
	assign samp_out  = (timer_in == '0) ? level_s1 : st_q.out_level;
	assign timer_dec = (timer_in > tick_period_q) ? timer_in - tick_period_q : '0;

	always_comb begin
		st_nxt   = st_q;
		rise_nxt = 1'b0;
		fall_nxt = 1'b0;
		case (action_s1)
			ACT_SAMPLE: begin
				if (st_q.enabled) begin
					st_nxt.last_raw = level_s1;
					if (st_q.startup_pending) begin
						st_nxt.out_level       = level_s1;
						st_nxt.last_out        = level_s1;
						st_nxt.hold_timer      = '0;
						st_nxt.startup_pending = 1'b0;
						rise_nxt               = level_s1;
						fall_nxt               = !level_s1;
					end else begin
						st_nxt.restart_pending = 1'b0;
						st_nxt.out_level       = samp_out;
						st_nxt.last_out        = samp_out;
						if (samp_out == level_s1) begin
							st_nxt.hold_timer = level_s1 ? fall_delay_q : rise_delay_q;
						end else begin
							st_nxt.hold_timer = timer_dec;
						end
						rise_nxt = samp_out && !st_q.last_out;
						fall_nxt = !samp_out && st_q.last_out;
					end
				end
			end
			ACT_RESTART: begin
				st_nxt.restart_pending = 1'b1;
			end
			ACT_ENABLE: begin
				st_nxt.enabled         = 1'b1;
				st_nxt.startup_pending = 1'b1;
			end
			default: begin
				st_nxt.enabled = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= FILT_STATE_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			filtered_level <= st_nxt.out_level;
			raw_level      <= st_nxt.last_raw;
			rise_event     <= rise_nxt;
			fall_event     <= fall_nxt;
			is_enabled     <= st_nxt.enabled;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_event_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(rise_event && fall_event))
		else $error("rise and fall flagged together");

	a_rise_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rise_event) |-> (filtered_level && is_enabled))
		else $error("rise flagged without high enabled output");

	a_fall_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fall_event) |-> (!filtered_level && is_enabled))
		else $error("fall flagged without low enabled output");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(action_s1) && $stable(level_s1)))
		else $error("stage 1 lost a stalled transaction");
`endif

endmodule

`default_nettype wire
